// ===== hw/rtl/tvzt_pkg.sv =====
package tvzt_pkg;

    localparam int TABLE_SIZE = 8;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    localparam int ZONE_W = 16;
    localparam int TIME_W = 32;
    localparam int MASK_W = 64;
    localparam int TZ_W   = 16;
    localparam int OFFS_W = TZ_W + 6;
    localparam int SEC_PER_MIN = 60;

    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 120;

    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_ADD       = 2'd1;
    localparam logic [1:0] REQ_STOP_MASK = 2'd2;
    localparam logic [1:0] REQ_STOP_ALL  = 2'd3;

    localparam logic [1:0] PH_PENDING = 2'd0;
    localparam logic [1:0] PH_RUNNING = 2'd1;
    localparam logic [1:0] PH_STOPREQ = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [1:0]        phase;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic [MASK_W-1:0] valves;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              zone_we;
        logic [ZONE_W-1:0] zone;
        logic              phase_we;
        logic [1:0]        phase;
        logic              fill_we;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic [MASK_W-1:0] valves;
    } wr_cmd_t;

endpackage

// ===== hw/rtl/tvzt_table.sv =====
module tvzt_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tvzt_pkg::IDX_W-1:0]    rd_idx,
    output tvzt_pkg::entry_t              rd_entry,
    input  tvzt_pkg::wr_cmd_t             wr
);

    logic [tvzt_pkg::ZONE_W-1:0] zone_reg   [tvzt_pkg::TABLE_SIZE];
    logic [1:0]                  phase_reg  [tvzt_pkg::TABLE_SIZE];
    logic [tvzt_pkg::TIME_W-1:0] start_reg  [tvzt_pkg::TABLE_SIZE];
    logic [tvzt_pkg::TIME_W-1:0] stop_reg   [tvzt_pkg::TABLE_SIZE];
    logic [tvzt_pkg::MASK_W-1:0] valves_reg [tvzt_pkg::TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < tvzt_pkg::TABLE_SIZE; n++) begin
                zone_reg[n] <= '0;
            end
        end else if (wr.zone_we) begin
            zone_reg[wr.idx] <= wr.zone;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.phase_we) begin
            phase_reg[wr.idx] <= wr.phase;
        end
        if (wr.fill_we) begin
            start_reg[wr.idx]  <= wr.start;
            stop_reg[wr.idx]   <= wr.stop;
            valves_reg[wr.idx] <= wr.valves;
        end
    end

    assign rd_entry.zone   = zone_reg[rd_idx];
    assign rd_entry.phase  = phase_reg[rd_idx];
    assign rd_entry.start  = start_reg[rd_idx];
    assign rd_entry.stop   = stop_reg[rd_idx];
    assign rd_entry.valves = valves_reg[rd_idx];

endmodule

// ===== hw/rtl/timed_valve_zone_table_unit.sv =====
// Timed valve zone table.
// Requests enter on the s_ channel (tuser = request type, tdata = zone id,
// run time, valve mask, current time, valve state). Each request yields zero
// or more start/finish notices (m_tuser 1 or 2) and then one summary item
// (m_tuser 0, m_tlast high) carrying the valve state and status flags.
// One request is worked at a time; s_tready is high only while idle.
// Each request walks the table through the single read port, with one
// sequencer reading entry by entry: add walks it and then writes the entry,
// stop by mask / stop all walk it once, and tick walks it once and, for every
// zone that finishes, walks the whole table again to collect the valves that
// other zones still use before it loads the finish notice.
// A result waits in the output register; while the receiver stalls, the
// sequencer holds at the next notice or summary. s_tready rises at the edge
// that loads the summary. cfg_we writes the time zone offset in minutes; it
// is to be written only while idle, a rule for the user that the block
// itself does not enforce.
// Reset empties the table, clears the offset and the running flag, and drops
// any pending result.
module timed_valve_zone_table_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tvzt_pkg::TZ_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // zone_id[15:0], run_time[47:16], port_mask[111:48], now_time[143:112],
    // port_state_in[207:144]
    input  logic [tvzt_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // port_state_out[63:0], man_running[64], accepted[65], note_zone[81:66],
    // note_time[113:82], zero[119:114]
    output logic [tvzt_pkg::M_DATA_W-1:0]   m_tdata,
    // note_kind[1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WALK,
        S_ADD_WR,
        S_STOP_WALK,
        S_TICK,
        S_USED,
        S_FIN,
        S_SUM
    } state_t;

    state_t                        state_reg;
    logic [tvzt_pkg::IDX_W-1:0]    i_reg;
    logic [tvzt_pkg::IDX_W-1:0]    k_reg;
    logic [tvzt_pkg::IDX_W-1:0]    cur_idx_reg;
    logic [tvzt_pkg::ZONE_W-1:0]   cur_zone_reg;
    logic [tvzt_pkg::TIME_W-1:0]   cur_start_reg;
    logic [tvzt_pkg::MASK_W-1:0]   cur_valves_reg;
    logic [tvzt_pkg::MASK_W-1:0]   used_reg;

    logic [1:0]                    req_reg;
    logic [tvzt_pkg::ZONE_W-1:0]   zone_reg;
    logic [tvzt_pkg::TIME_W-1:0]   run_reg;
    logic [tvzt_pkg::MASK_W-1:0]   mask_reg;
    logic [tvzt_pkg::TIME_W-1:0]   now_reg;
    logic [tvzt_pkg::MASK_W-1:0]   ports_reg;
    logic                          acc_reg;

    logic                          match_found_reg;
    logic [tvzt_pkg::IDX_W-1:0]    match_idx_reg;
    logic                          free_found_reg;
    logic [tvzt_pkg::IDX_W-1:0]    free_idx_reg;

    logic [tvzt_pkg::TZ_W-1:0]     tz_reg;
    logic                          any_running_reg;

    logic                          out_valid_reg;
    logic [1:0]                    out_kind_reg;
    logic                          out_last_reg;
    logic [tvzt_pkg::MASK_W-1:0]   out_ports_reg;
    logic                          out_run_reg;
    logic                          out_acc_reg;
    logic [tvzt_pkg::ZONE_W-1:0]   out_zone_reg;
    logic [tvzt_pkg::TIME_W-1:0]   out_time_reg;

    logic [tvzt_pkg::IDX_W-1:0]    rd_idx;
    tvzt_pkg::entry_t              rd;
    tvzt_pkg::wr_cmd_t             wr;
    logic                          slot_free;
    logic                          occupied;
    logic [tvzt_pkg::OFFS_W-1:0]   offs;
    logic [tvzt_pkg::TIME_W-1:0]   stamp;
    logic                          tick_run;

    assign slot_free = !out_valid_reg || m_tready;
    assign occupied  = (rd.zone != '0);
    assign offs      = tvzt_pkg::OFFS_W'(tz_reg) * tvzt_pkg::OFFS_W'(tvzt_pkg::SEC_PER_MIN);
    assign stamp     = cur_start_reg - tvzt_pkg::TIME_W'(offs);
    assign tick_run  = (ports_reg != '0);

    always_comb begin
        case (state_reg)
            S_USED:  rd_idx = k_reg;
            S_FIN:   rd_idx = cur_idx_reg;
            default: rd_idx = i_reg;
        endcase
    end

    tvzt_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (rd_idx),
        .rd_entry (rd),
        .wr       (wr)
    );

    always_comb begin
        wr          = '0;
        wr.idx      = i_reg;
        wr.zone     = zone_reg;
        wr.start    = now_reg;
        wr.stop     = now_reg + run_reg;
        wr.valves   = mask_reg;
        case (state_reg)
            S_ADD_WR: begin
                wr.idx = match_found_reg ? match_idx_reg : free_idx_reg;
                if (match_found_reg || free_found_reg) begin
                    wr.zone_we  = 1'b1;
                    wr.phase_we = 1'b1;
                    wr.fill_we  = 1'b1;
                    wr.phase    = (run_reg != '0) ? tvzt_pkg::PH_PENDING
                                                  : tvzt_pkg::PH_STOPREQ;
                end
            end
            S_STOP_WALK: begin
                wr.phase = tvzt_pkg::PH_STOPREQ;
                if (occupied && (req_reg == tvzt_pkg::REQ_STOP_ALL ||
                                 (mask_reg & rd.valves) != '0)) begin
                    wr.phase_we = 1'b1;
                end
            end
            S_TICK: begin
                if (occupied && rd.phase == tvzt_pkg::PH_PENDING && slot_free) begin
                    wr.phase_we = 1'b1;
                    wr.phase    = tvzt_pkg::PH_RUNNING;
                end else if (occupied && rd.phase == tvzt_pkg::PH_RUNNING &&
                             now_reg >= rd.stop) begin
                    wr.phase_we = 1'b1;
                    wr.phase    = tvzt_pkg::PH_STOPREQ;
                end
            end
            S_FIN: begin
                wr.idx   = cur_idx_reg;
                wr.zone  = '0;
                wr.phase = tvzt_pkg::PH_STOPPED;
                if (slot_free) begin
                    wr.zone_we  = 1'b1;
                    wr.phase_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            any_running_reg <= 1'b0;
            tz_reg          <= '0;
            i_reg           <= '0;
            k_reg           <= '0;
        end else begin
            if (cfg_we) begin
                tz_reg <= cfg_wdata;
            end
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        req_reg         <= s_tuser;
                        zone_reg        <= s_tdata[15:0];
                        run_reg         <= s_tdata[47:16];
                        mask_reg        <= s_tdata[111:48];
                        now_reg         <= s_tdata[143:112];
                        ports_reg       <= s_tdata[207:144];
                        acc_reg         <= 1'b1;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        i_reg           <= '0;
                        case (s_tuser)
                            tvzt_pkg::REQ_TICK: state_reg <= S_TICK;
                            tvzt_pkg::REQ_ADD:  state_reg <= S_ADD_WALK;
                            default:            state_reg <= S_STOP_WALK;
                        endcase
                    end
                end
                S_ADD_WALK: begin
                    if (!match_found_reg && rd.zone == zone_reg) begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= i_reg;
                    end
                    if (!free_found_reg && !occupied) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= i_reg;
                    end
                    if (i_reg == tvzt_pkg::LAST_IDX) begin
                        state_reg <= S_ADD_WR;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_ADD_WR: begin
                    acc_reg   <= match_found_reg || free_found_reg;
                    state_reg <= S_SUM;
                end
                S_STOP_WALK: begin
                    if (i_reg == tvzt_pkg::LAST_IDX) begin
                        state_reg <= S_SUM;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_TICK: begin
                    if (occupied && rd.phase == tvzt_pkg::PH_STOPREQ) begin
                        cur_idx_reg    <= i_reg;
                        cur_zone_reg   <= rd.zone;
                        cur_start_reg  <= rd.start;
                        cur_valves_reg <= rd.valves;
                        used_reg       <= '0;
                        k_reg          <= '0;
                        state_reg      <= S_USED;
                    end else if (occupied && rd.phase == tvzt_pkg::PH_PENDING &&
                                 !slot_free) begin
                        state_reg <= S_TICK;
                    end else begin
                        if (occupied && (rd.phase == tvzt_pkg::PH_PENDING ||
                                         rd.phase == tvzt_pkg::PH_RUNNING)) begin
                            ports_reg <= ports_reg | rd.valves;
                        end
                        if (occupied && rd.phase == tvzt_pkg::PH_PENDING) begin
                            out_valid_reg <= 1'b1;
                            out_kind_reg  <= tvzt_pkg::KIND_START;
                            out_last_reg  <= 1'b0;
                            out_ports_reg <= '0;
                            out_run_reg   <= 1'b0;
                            out_acc_reg   <= 1'b0;
                            out_zone_reg  <= rd.zone;
                            out_time_reg  <= '0;
                        end
                        if (i_reg == tvzt_pkg::LAST_IDX) begin
                            state_reg <= S_SUM;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                S_USED: begin
                    if (k_reg != cur_idx_reg && occupied) begin
                        used_reg <= used_reg | rd.valves;
                    end
                    if (k_reg == tvzt_pkg::LAST_IDX) begin
                        state_reg <= S_FIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_FIN: begin
                    if (slot_free) begin
                        ports_reg     <= ports_reg & ~(cur_valves_reg & ~used_reg);
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= tvzt_pkg::KIND_FINISH;
                        out_last_reg  <= 1'b0;
                        out_ports_reg <= '0;
                        out_run_reg   <= 1'b0;
                        out_acc_reg   <= 1'b0;
                        out_zone_reg  <= cur_zone_reg;
                        out_time_reg  <= stamp;
                        if (i_reg == tvzt_pkg::LAST_IDX) begin
                            state_reg <= S_SUM;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_TICK;
                        end
                    end
                end
                S_SUM: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= tvzt_pkg::KIND_SUMMARY;
                        out_last_reg  <= 1'b1;
                        out_ports_reg <= ports_reg;
                        out_acc_reg   <= acc_reg;
                        out_zone_reg  <= '0;
                        out_time_reg  <= '0;
                        if (req_reg == tvzt_pkg::REQ_TICK) begin
                            any_running_reg <= tick_run;
                            out_run_reg     <= tick_run;
                        end else begin
                            out_run_reg <= any_running_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_time_reg, out_zone_reg, out_acc_reg, out_run_reg,
                       out_ports_reg};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a request is in progress");

    a_last_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == tvzt_pkg::KIND_SUMMARY)
        else $error("final result is not a summary");

    a_notice_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[65:0] == '0 &&
                                 (m_tuser == tvzt_pkg::KIND_START ||
                                  m_tuser == tvzt_pkg::KIND_FINISH))
        else $error("malformed notice");

    a_used_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_USED |=> state_reg == S_USED || state_reg == S_FIN)
        else $error("overlap walk left early");

endmodule
